### hdl/flag_record_stream_parser_macros.svh
// Assertion macros used by the flag record parser back end.
`ifndef FLAG_RECORD_STREAM_PARSER_MACROS_SVH
`define FLAG_RECORD_STREAM_PARSER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FRSP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FRSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/frsp_pkg.sv
// ----------------------------------------------------------------------------
// frsp_pkg
// Types and constants shared by the flag record stream parser.
// ----------------------------------------------------------------------------
`default_nettype none
package frsp_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned QueueDepthDefault = 2;

  // Flag kinds carried in the low three bits of a record header.
  localparam logic [2:0] KindFalse = 3'd0;
  localparam logic [2:0] KindTrue  = 3'd1;
  localparam logic [2:0] KindInt   = 3'd2;
  localparam logic [2:0] KindFloat = 3'd3;
  localparam logic [2:0] KindExt   = 3'd5;

  typedef enum logic [2:0] {
    EV_COUNT   = 3'd0,
    EV_NAME    = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_DONE    = 3'd3,
    EV_ERROR   = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_OVERLONG = 3'd2,
    ERR_KIND     = 3'd3,
    ERR_LENGTH   = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    PH_COUNT   = 4'd0,
    PH_HEADER  = 4'd1,
    PH_NAMELEN = 4'd2,
    PH_NAME    = 4'd3,
    PH_INT     = 4'd4,
    PH_FLOAT   = 4'd5,
    PH_PLEN    = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  // Classified beat handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       cont;       // continuation bit of a varint byte
  } beat_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  byte_value;
    logic [63:0] record_number;
    logic [2:0]  flag_kind;
    logic [63:0] name_number;
    logic        name_is_number;
    logic [63:0] scalar_value;
    logic [31:0] payload_length;
    logic        all_done;
    logic [2:0]  error_code;
  } result_t;

endpackage
`default_nettype wire

### hdl/frsp_if.sv
// ----------------------------------------------------------------------------
// frsp_in_if / frsp_out_if
// Valid/ready channels for input bytes and parser results.
// ----------------------------------------------------------------------------
`default_nettype none
interface frsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface frsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  byte_value;
  logic [63:0] record_number;
  logic [2:0]  flag_kind;
  logic [63:0] name_number;
  logic        name_is_number;
  logic [63:0] scalar_value;
  logic [31:0] payload_length;
  logic        all_done;
  logic [2:0]  error_code;
  modport source (output valid, output event_res, output byte_value,
                  output record_number, output flag_kind, output name_number,
                  output name_is_number, output scalar_value,
                  output payload_length, output all_done, output error_code,
                  input ready);
  modport sink (input valid, input event_res, input byte_value,
                input record_number, input flag_kind, input name_number,
                input name_is_number, input scalar_value,
                input payload_length, input all_done, input error_code,
                output ready);
endinterface
`default_nettype wire

### hdl/flag_record_stream_parser.sv
// ----------------------------------------------------------------------------
// flag_record_stream_parser
// Streaming parser for an inflated flag record blob.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  in_if    | sink      | data_byte, is_last: one blob byte per beat
//  out_if   | source    | one parser event per beat (count, byte, record, error)
//
// One input beat is taken per clock cycle while the queue has room, so beats
// may follow back to back; the back end parses the oldest queued beat
// combinationally and registers any result at the edge that pops it.
// The back end takes no beat while a result waits unaccepted; a new result
// loads in the same cycle as the waiting one is accepted.
// Reset is asynchronous and active low, clearing the queue and parser state.
// An output stall holds the back end, then fills the queue, then drops
// in_if.ready.
`default_nettype none
module flag_record_stream_parser
  import frsp_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDefault,
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  frsp_in_if.sink    in_if,
  frsp_out_if.source out_if
);
  // Front end: classifies bytes and pushes them into the queue.
  logic  push, full, pop, empty;
  beat_t push_data, pop_data;

  frsp_front u_front (
    .in_if       (in_if),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue lets the front keep accepting while the back end waits.
  frsp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back end: the record state machine and the result register.
  frsp_back #(.LengthBits(LengthBits)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .beat_i  (pop_data),
    .pop_o   (pop),
    .out_if  (out_if)
  );
endmodule
`default_nettype wire

### hdl/frsp_queue.sv
// ----------------------------------------------------------------------------
// frsp_queue
// Small register FIFO that decouples the byte front end from the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module frsp_queue
  import frsp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  beat_t      push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output beat_t      pop_data_o,
  output logic       empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  beat_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

### hdl/frsp_front.sv
// ----------------------------------------------------------------------------
// frsp_front
// Accepts input beats and tags each with its varint continuation bit.
// ----------------------------------------------------------------------------
`default_nettype none
module frsp_front
  import frsp_pkg::*;
(
  frsp_in_if.sink   in_if,
  input  wire logic q_full_i,
  output logic      push_o,
  output beat_t     push_data_o
);
  assign in_if.ready           = !q_full_i;
  assign push_o                = in_if.valid && !q_full_i;
  assign push_data_o.data_byte = in_if.data_byte;
  assign push_data_o.is_last   = in_if.is_last;
  assign push_data_o.cont      = in_if.data_byte[7];
endmodule
`default_nettype wire

### hdl/frsp_back.sv
// ----------------------------------------------------------------------------
// frsp_back
// Parser FSM: one beat per cycle into a registered result, unless it stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flag_record_stream_parser_macros.svh"
module frsp_back
  import frsp_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  beat_t      beat_i,
  output logic       pop_o,
  frsp_out_if.source out_if
);
  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  vcnt_q, vcnt_d;
  logic [63:0] left_q, left_d;
  logic [63:0] rec_q, rec_d;
  logic [63:0] base_q, base_d;
  logic [2:0]  kind_q, kind_d;
  logic        numd_q, numd_d;
  logic [63:0] bleft_q, bleft_d;
  logic [31:0] ptot_q, ptot_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic        halt_q, halt_d;

  logic        res_vld_q;
  result_t     res_q;
  result_t     res_d;
  logic        emit;
  logic        take;

  // Varint helpers.
  logic [63:0] vshift, vval;
  logic        vover, vfin;
  logic [63:0] fshift;
  logic        len_big;
  logic [63:0] bleft_m1;

  assign take  = !empty_i && (!res_vld_q || out_if.ready);
  assign pop_o = take;

  always_comb begin
    vshift = 64'(beat_i.data_byte[6:0]) << (7 * vcnt_q);
    vval   = acc_q | vshift;
    vfin   = !beat_i.cont;
    vover  = beat_i.cont && (vcnt_q == 4'd9);
    fshift = 64'(beat_i.data_byte) << {fcnt_q, 3'b000};
    if (LengthBits >= 64) len_big = 1'b0;
    else                  len_big = (vval >> LengthBits) != '0;
    bleft_m1 = bleft_q - 64'd1;
  end

  always_comb begin
    logic       fin;
    logic       start_pl;
    logic [7:0] sbv;
    phase_d = phase_q; acc_d = acc_q; vcnt_d = vcnt_q; left_d = left_q;
    rec_d = rec_q; base_d = base_q; kind_d = kind_q; numd_d = numd_q;
    bleft_d = bleft_q; ptot_d = ptot_q; fcnt_d = fcnt_q; halt_d = halt_q;
    emit = 1'b0; fin = 1'b0; start_pl = 1'b0; sbv = '0;
    res_d = '0;
    res_d.record_number = rec_q;

    if (!halt_q && phase_q != PH_DONE) begin
      unique case (phase_q) inside
        PH_COUNT, PH_HEADER, PH_NAMELEN, PH_INT, PH_PLEN: begin
          if (vfin) begin
            acc_d = '0; vcnt_d = '0;
          end else begin
            acc_d = vval; vcnt_d = vcnt_q + 4'd1;
          end
          if (vover) begin
            emit = 1'b1; halt_d = 1'b1;
            res_d.event_res = EV_ERROR; res_d.error_code = ERR_OVERLONG;
          end else if (vfin) begin
            unique case (phase_q)
              PH_COUNT: begin
                left_d = vval;
                phase_d = (vval != '0) ? PH_HEADER : PH_DONE;
                emit = 1'b1;
                res_d.event_res = EV_COUNT;
                res_d.record_number = vval;
                res_d.all_done = (vval == '0);
              end
              PH_HEADER: begin
                ptot_d = '0;
                if (vval[2:0] > KindExt) begin
                  kind_d = '0; emit = 1'b1; halt_d = 1'b1;
                  res_d.event_res = EV_ERROR; res_d.error_code = ERR_KIND;
                end else begin
                  kind_d = vval[2:0];
                  if (vval[63:3] == '0) begin
                    numd_d = 1'b0; phase_d = PH_NAMELEN;
                  end else begin
                    numd_d = 1'b1; base_d = base_q + {3'b000, vval[63:3]};
                    start_pl = 1'b1;
                  end
                end
              end
              PH_NAMELEN: begin
                if (len_big) begin
                  emit = 1'b1; halt_d = 1'b1;
                  res_d.event_res = EV_ERROR; res_d.error_code = ERR_LENGTH;
                end else if (vval == '0) begin
                  start_pl = 1'b1;
                end else begin
                  bleft_d = vval; phase_d = PH_NAME;
                end
              end
              PH_INT: begin
                fin = 1'b1; res_d.scalar_value = vval;
              end
              default: begin
                if (len_big) begin
                  emit = 1'b1; halt_d = 1'b1;
                  res_d.event_res = EV_ERROR; res_d.error_code = ERR_LENGTH;
                end else begin
                  ptot_d = vval[31:0];
                  if (vval == '0) fin = 1'b1;
                  else begin
                    bleft_d = vval; phase_d = PH_PAYLOAD;
                  end
                end
              end
            endcase
          end
        end
        PH_NAME: begin
          bleft_d = bleft_m1;
          if (bleft_m1 == '0) begin
            start_pl = 1'b1; sbv = beat_i.data_byte;
          end
          emit = 1'b1;
          res_d.event_res = EV_NAME; res_d.byte_value = beat_i.data_byte;
        end
        PH_FLOAT: begin
          if (fcnt_q == 3'd7) begin
            acc_d = '0; fcnt_d = '0; fin = 1'b1; sbv = beat_i.data_byte;
            res_d.scalar_value = acc_q | fshift;
          end else begin
            acc_d = acc_q | fshift; fcnt_d = fcnt_q + 3'd1; emit = 1'b1;
            res_d.event_res = EV_PAYLOAD; res_d.byte_value = beat_i.data_byte;
          end
        end
        PH_PAYLOAD: begin
          bleft_d = bleft_m1;
          sbv = beat_i.data_byte;
          if (bleft_m1 == '0) fin = 1'b1;
          else begin
            emit = 1'b1;
            res_d.event_res = EV_PAYLOAD; res_d.byte_value = beat_i.data_byte;
            res_d.payload_length = ptot_q;
          end
        end
        default: ;
      endcase

      if (start_pl) begin
        acc_d = '0; vcnt_d = '0; fcnt_d = '0;
        unique case (kind_d) inside
          KindFalse, KindTrue: begin
            fin = 1'b1; res_d.scalar_value = 64'(kind_d);
          end
          KindInt:   phase_d = PH_INT;
          KindFloat: phase_d = PH_FLOAT;
          default:   phase_d = PH_PLEN;
        endcase
      end

      if (fin) begin
        emit = 1'b1;
        res_d.event_res  = EV_DONE;
        res_d.byte_value = sbv;
        res_d.payload_length = ptot_d;
        rec_d  = rec_q + 64'd1;
        left_d = left_q - 64'd1;
        res_d.all_done = (left_d == '0);
        phase_d = (left_d == '0) ? PH_DONE : PH_HEADER;
      end
      if (res_d.event_res != EV_COUNT) begin
        res_d.flag_kind = kind_d;
        res_d.name_number = base_d;
        res_d.name_is_number = numd_d;
      end
    end

    if (beat_i.is_last) begin
      if (!halt_q && phase_q != PH_DONE && !(phase_d == PH_DONE && !halt_d)
          && !halt_d) begin
        emit = 1'b1;
        res_d = '0;
        res_d.event_res = EV_ERROR;
        res_d.error_code = ERR_TRUNC;
        res_d.record_number = rec_d;
        res_d.flag_kind = kind_d;
        res_d.name_number = base_d;
        res_d.name_is_number = numd_d;
      end
      phase_d = PH_COUNT; acc_d = '0; vcnt_d = '0; left_d = '0; rec_d = '0;
      base_d = '0; kind_d = '0; numd_d = 1'b0; bleft_d = '0; ptot_d = '0;
      fcnt_d = '0; halt_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT; acc_q <= '0; vcnt_q <= '0; left_q <= '0;
      rec_q <= '0; base_q <= '0; kind_q <= '0; numd_q <= 1'b0;
      bleft_q <= '0; ptot_q <= '0; fcnt_q <= '0; halt_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; acc_q <= acc_d; vcnt_q <= vcnt_d; left_q <= left_d;
        rec_q <= rec_d; base_q <= base_d; kind_q <= kind_d; numd_q <= numd_d;
        bleft_q <= bleft_d; ptot_q <= ptot_d; fcnt_q <= fcnt_d;
        halt_q <= halt_d;
        res_vld_q <= emit;
      end else if (out_if.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) res_q <= res_d;
  end

  assign out_if.valid          = res_vld_q;
  assign out_if.event_res      = res_q.event_res;
  assign out_if.byte_value     = res_q.byte_value;
  assign out_if.record_number  = res_q.record_number;
  assign out_if.flag_kind      = res_q.flag_kind;
  assign out_if.name_number    = res_q.name_number;
  assign out_if.name_is_number = res_q.name_is_number;
  assign out_if.scalar_value   = res_q.scalar_value;
  assign out_if.payload_length = res_q.payload_length;
  assign out_if.all_done       = res_q.all_done;
  assign out_if.error_code     = res_q.error_code;

  `FRSP_ASSERT_IMP(a_err_code, clk_i, rst_ni,
    res_vld_q && res_q.event_res == EV_ERROR, res_q.error_code != ERR_NONE,
    "error result without a code")
  `FRSP_ASSERT_IMP(a_no_pop_stall, clk_i, rst_ni,
    res_vld_q && !out_if.ready, !pop_o, "beat taken while result stalled")
  `FRSP_ASSERT_NEXT(a_halt_err, clk_i, rst_ni,
    take && !halt_q && halt_d, res_vld_q && res_q.event_res == EV_ERROR,
    "halt without an error result")
  `FRSP_ASSERT_NEXT(a_last_restart, clk_i, rst_ni,
    take && beat_i.is_last, phase_q == PH_COUNT && !halt_q,
    "parser did not restart after last beat")
endmodule
`default_nettype wire
